// ----- rtl/core/kot_pkg.sv -----
`timescale 1ns / 1ps
package kot_pkg;

  localparam int POSITION_BITS = 24;
  localparam int LINE_BITS     = 20;
  localparam int QUEUE_DEPTH   = 8;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int MAX_TOKENS    = 3;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LINE_BITS-1:0]     line_t;

  localparam pos_t  POS_MAX  = {POSITION_BITS{1'b1}};
  localparam line_t LINE_MAX = {LINE_BITS{1'b1}};

  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_NUMBER = 5'd2;
  localparam logic [4:0] KIND_SYMID  = 5'd3;
  localparam logic [4:0] KIND_SYMNUM = 5'd4;
  localparam logic [4:0] KIND_OP     = 5'd5;
  localparam logic [4:0] KIND_KW     = 5'd6;
  localparam logic [4:0] KIND_ERR    = 5'd16;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;

  localparam logic [3:0] KW_CASE  = 4'd3;
  localparam logic [3:0] KW_CONT  = 4'd9;
  localparam logic [3:0] KW_COUNT = 4'd10;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] operator_code;
    logic [23:0] start_position;
    logic [23:0] token_length;
    logic [19:0] line_number;
    logic [23:0] column;
    logic        last_of_run;
  } token_item_t;

  // tokens caused by one byte, front to queue
  typedef struct packed {
    logic        valid;
    logic [1:0]  count;
    token_item_t [MAX_TOKENS-1:0] tok;
  } token_bundle_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"d", "o", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0},
    '{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"c", "a", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"t", "h", "e", "n", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"s", "w", "i", "t", "c", "h", 8'h0, 8'h0},
    '{"b", "r", "e", "a", "k", 8'h0, 8'h0, 8'h0},
    '{"c", "o", "n", "t", "i", "n", "u", "e"}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd5, 4'd3, 4'd4, 4'd2, 4'd4, 4'd4, 4'd6, 4'd5, 4'd8
  };

  function automatic logic [3:0] kw_len(input logic [3:0] idx);
    if (idx < KW_COUNT) return KW_LEN[idx];
    return 4'd0;
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [3:0] m);
    if (idx < KW_COUNT && m < 4'd8) return KW_TEXT[idx][m[2:0]];
    return 8'h0;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex_us(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == CH_US;
  endfunction

  function automatic pos_t pos_inc(input pos_t v);
    return (v < POS_MAX) ? v + 1'b1 : POS_MAX;
  endfunction

  function automatic pos_t pos_diff(input pos_t a, input pos_t b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

// ----- rtl/core/keyword_operator_tokenizer_core.sv -----
`timescale 1ns / 1ps
// A token passes from the front through the queue into the output register before it leaves.
// Throughput: one byte per cycle while tokens average at most one a byte and the output is not stalled; the token queue
// (eight items, up to three written per byte) takes a byte only with three free slots.
// Output: one token item per cycle from the output register while token_stall is low.
// Reset: synchronous, active high; clears scan state, queue pointers and output valid.
module keyword_operator_tokenizer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  kot_pkg::text_item_t  text,
  output logic                 token_valid,
  input  logic                 token_stall,
  output kot_pkg::token_item_t token
);
  import kot_pkg::*;

  token_bundle_t bundle;
  token_item_t   head;
  logic          room, pop, nonempty, accept;

  // a byte is taken only while the queue can hold every token it may cause
  assign text_stall = !room;
  assign accept     = text_valid && room;

  // front: scan state, classification, up to three tokens per item
  kot_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .text   (text),
    .bundle (bundle)
  );

  // token queue decouples scanning from the downstream stall
  kot_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .room     (room),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  // back: output register, one token item per handshake
  kot_back u_back (
    .clk         (clk),
    .rst         (rst),
    .nonempty    (nonempty),
    .head        (head),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

endmodule

// ----- rtl/core/kot_front.sv -----
`timescale 1ns / 1ps
module kot_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  kot_pkg::text_item_t    text,
  output kot_pkg::token_bundle_t bundle
);
  import kot_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_KEYWORD  = 7'b0000010,
    PH_IDENT    = 7'b0000100,
    PH_NUMBER   = 7'b0001000,
    PH_OPERATOR = 7'b0010000,
    PH_SYMSTART = 7'b0100000,
    PH_HALTED   = 7'b1000000
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] kw_idx, kw_idx_next, kw_cnt, kw_cnt_next;
  logic [7:0] pend, pend_next;
  logic       sym, sym_next;
  pos_t       pos, pos_next, lstart, lstart_next, tstart, tstart_next;
  line_t      line, line_next;

  token_item_t toks [MAX_TOKENS];
  logic [1:0]  n;

  function automatic token_item_t mk(input logic [4:0] kind, input logic [15:0] code,
                                     input pos_t start, input pos_t len,
                                     input line_t ln, input pos_t ls);
    token_item_t t;
    t.token_kind     = kind;
    t.operator_code  = code;
    t.start_position = start;
    t.token_length   = len;
    t.line_number    = ln;
    t.column         = pos_diff(start, ls);
    t.last_of_run    = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [7:0] ch;
    logic       do_start;
    logic       hit;
    logic [3:0] m;
    pos_t       p;
    c = text.text_byte;
    p = pos;
    phase_next  = phase;
    kw_idx_next = kw_idx;
    kw_cnt_next = kw_cnt;
    pend_next   = pend;
    sym_next    = sym;
    line_next   = line;
    lstart_next = lstart;
    tstart_next = tstart;
    do_start    = 1'b0;
    n           = 2'd0;
    ch          = pend;
    m           = kw_cnt;
    hit         = 1'b0;
    for (int i = 0; i < MAX_TOKENS; i++) toks[i] = '0;

    case (phase)
      PH_IDLE: do_start = 1'b1;
      PH_OPERATOR: begin
        phase_next = PH_IDLE;
        pend_next  = 8'h0;
        if (ch == CH_BANG && c == CH_EQ) begin
          toks[n] = mk(KIND_OP, {CH_BANG, CH_EQ}, tstart, pos_t'(2), line_next, lstart_next);
          n = n + 2'd1;
        end else if (ch != CH_BANG && c == ch) begin
          toks[n] = mk(KIND_OP, {ch, ch}, tstart, pos_t'(2), line_next, lstart_next);
          n = n + 2'd1;
        end else begin
          toks[n] = mk(KIND_OP, {8'h0, ch}, tstart, pos_t'(1), line_next, lstart_next);
          n = n + 2'd1;
          do_start = 1'b1;
        end
      end
      PH_KEYWORD: begin
        hit = kw_idx < KW_COUNT && kw_cnt < kw_len(kw_idx) && c == kw_char(kw_idx, kw_cnt);
        if (hit || (kw_idx == KW_CASE && kw_cnt == 4'd1 && c == "o")) begin
          // "co" switches the candidate from case to continue
          kw_idx_next = hit ? kw_idx : KW_CONT;
          m           = hit ? kw_cnt + 4'd1 : 4'd2;
          kw_cnt_next = m;
          if (m >= kw_len(kw_idx_next)) begin
            toks[n] = mk(KIND_KW + {1'b0, kw_idx_next}, 16'h0, tstart,
                         pos_t'(kw_len(kw_idx_next)), line_next, lstart_next);
            n = n + 2'd1;
            phase_next  = PH_IDLE;
            kw_idx_next = 4'd0;
            kw_cnt_next = 4'd0;
          end
        end else begin
          phase_next  = PH_IDENT;
          kw_idx_next = 4'd0;
          kw_cnt_next = 4'd0;
          if (!is_letter(c)) begin
            toks[n] = mk(sym ? KIND_SYMID : KIND_IDENT, 16'h0, tstart, pos_diff(p, tstart),
                         line_next, lstart_next);
            n = n + 2'd1;
            phase_next = PH_IDLE;
            sym_next   = 1'b0;
            do_start   = 1'b1;
          end
        end
      end
      PH_IDENT: begin
        if (!is_letter(c)) begin
          toks[n] = mk(sym ? KIND_SYMID : KIND_IDENT, 16'h0, tstart, pos_diff(p, tstart),
                       line_next, lstart_next);
          n = n + 2'd1;
          phase_next = PH_IDLE;
          sym_next   = 1'b0;
          do_start   = 1'b1;
        end
      end
      PH_NUMBER: begin
        if (!is_hex_us(c)) begin
          toks[n] = mk(sym ? KIND_SYMNUM : KIND_NUMBER, 16'h0, tstart, pos_diff(p, tstart),
                       line_next, lstart_next);
          n = n + 2'd1;
          phase_next = PH_IDLE;
          sym_next   = 1'b0;
          do_start   = 1'b1;
        end
      end
      PH_SYMSTART: begin
        if (is_letter(c)) phase_next = PH_IDENT;
        else if (is_digit(c)) phase_next = PH_NUMBER;
        else begin
          toks[n] = mk(KIND_ERR, 16'h0, tstart, pos_diff(pos_inc(p), tstart),
                       line_next, lstart_next);
          n = n + 2'd1;
          sym_next   = 1'b0;
          phase_next = PH_HALTED;
        end
      end
      default: ;
    endcase

    if (do_start) begin
      tstart_next = p;
      if (c == " " || c == 8'h09 || c == CH_VT || c == 8'h0C) begin
        // blank
      end else if (c == CH_NL) begin
        line_next   = (line < LINE_MAX) ? line + 1'b1 : LINE_MAX;
        lstart_next = pos_inc(p);
      end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}" ||
                   c == ":" || c == "," || c == ";" || c == "+" || c == "-" || c == "*" ||
                   c == "/" || c == "^" || c == "~") begin
        toks[n] = mk(KIND_OP, {8'h0, c}, p, pos_t'(1), line_next, lstart_next);
        n = n + 2'd1;
      end else if (c == CH_BANG || c == CH_EQ || c == "&" || c == "|" || c == "<" ||
                   c == ">") begin
        pend_next  = c;
        phase_next = PH_OPERATOR;
      end else if (c == CH_DOLLAR) begin
        sym_next   = 1'b1;
        phase_next = PH_SYMSTART;
      end else if (c == "d" || c == "w" || c == "f" || c == "c" || c == "i" || c == "t" ||
                   c == "e" || c == "s" || c == "b") begin
        case (c)
          "d":     kw_idx_next = 4'd0;
          "w":     kw_idx_next = 4'd1;
          "f":     kw_idx_next = 4'd2;
          "c":     kw_idx_next = 4'd3;
          "i":     kw_idx_next = 4'd4;
          "t":     kw_idx_next = 4'd5;
          "e":     kw_idx_next = 4'd6;
          "s":     kw_idx_next = 4'd7;
          default: kw_idx_next = 4'd8;
        endcase
        kw_cnt_next = 4'd1;
        phase_next  = PH_KEYWORD;
      end else if (is_letter(c)) begin
        phase_next = PH_IDENT;
      end else if (is_digit(c)) begin
        phase_next = PH_NUMBER;
      end else begin
        toks[n] = mk(KIND_ERR, 16'h0, p, pos_t'(1), line_next, lstart_next);
        n = n + 2'd1;
        phase_next = PH_HALTED;
      end
    end

    pos_next = pos_inc(p);

    if (text.end_of_text) begin
      case (phase_next)
        PH_OPERATOR: begin
          toks[n] = mk(KIND_OP, {8'h0, pend_next}, tstart_next, pos_t'(1),
                       line_next, lstart_next);
          n = n + 2'd1;
        end
        PH_KEYWORD, PH_IDENT: begin
          toks[n] = mk(sym_next ? KIND_SYMID : KIND_IDENT, 16'h0, tstart_next,
                       pos_diff(pos_next, tstart_next), line_next, lstart_next);
          n = n + 2'd1;
        end
        PH_NUMBER: begin
          toks[n] = mk(sym_next ? KIND_SYMNUM : KIND_NUMBER, 16'h0, tstart_next,
                       pos_diff(pos_next, tstart_next), line_next, lstart_next);
          n = n + 2'd1;
        end
        PH_SYMSTART: begin
          toks[n] = mk(KIND_ERR, 16'h0, tstart_next, pos_diff(pos_next, tstart_next),
                       line_next, lstart_next);
          n = n + 2'd1;
        end
        default: ;
      endcase
      if (n != 2'd3) begin
        toks[n] = mk(KIND_END, 16'h0, pos_next, '0, line_next, lstart_next);
        n = n + 2'd1;
      end
      phase_next  = PH_IDLE;
      kw_idx_next = 4'd0;
      kw_cnt_next = 4'd0;
      pend_next   = 8'h0;
      sym_next    = 1'b0;
      pos_next    = '0;
      line_next   = line_t'(1);
      lstart_next = '0;
      tstart_next = '0;
    end

    if (n != 2'd0) toks[n - 2'd1].last_of_run = 1'b1;
  end

  always_comb begin
    bundle.valid = accept;
    bundle.count = n;
    for (int i = 0; i < MAX_TOKENS; i++) bundle.tok[i] = toks[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      kw_idx <= 4'd0;
      kw_cnt <= 4'd0;
      pend   <= 8'h0;
      sym    <= 1'b0;
      pos    <= '0;
      line   <= line_t'(1);
      lstart <= '0;
      tstart <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      kw_idx <= kw_idx_next;
      kw_cnt <= kw_cnt_next;
      pend   <= pend_next;
      sym    <= sym_next;
      pos    <= pos_next;
      line   <= line_next;
      lstart <= lstart_next;
      tstart <= tstart_next;
    end
  end

endmodule

// ----- rtl/core/kot_queue.sv -----
`timescale 1ns / 1ps
module kot_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  kot_pkg::token_bundle_t bundle,
  output logic                   room,
  input  logic                   pop,
  output logic                   nonempty,
  output kot_pkg::token_item_t   head
);
  import kot_pkg::*;

  token_item_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wptr, rptr;
  logic [QPTR_BITS:0]     count;
  logic [1:0]             nwr;

  assign nwr      = bundle.valid ? bundle.count : 2'd0;
  assign room     = count <= (QPTR_BITS+1)'(QUEUE_DEPTH - MAX_TOKENS);
  assign nonempty = count != '0;
  assign head     = entries[rptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (bundle.valid && 2'(i) < bundle.count)
        entries[wptr + QPTR_BITS'(i)] <= bundle.tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_BITS'(nwr);
      rptr  <= rptr + QPTR_BITS'(pop);
      count <= count + (QPTR_BITS+1)'(nwr) - (QPTR_BITS+1)'(pop);
    end
  end

endmodule

// ----- rtl/core/kot_back.sv -----
`timescale 1ns / 1ps
module kot_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 nonempty,
  input  kot_pkg::token_item_t head,
  output logic                 pop,
  output logic                 token_valid,
  input  logic                 token_stall,
  output kot_pkg::token_item_t token
);
  import kot_pkg::*;

  assign pop = nonempty && (!token_valid || !token_stall);

  always_ff @(posedge clk) begin
    if (rst) token_valid <= 1'b0;
    else if (!token_valid || !token_stall) token_valid <= nonempty;
  end

  always_ff @(posedge clk) begin
    if (pop) token <= head;
  end

endmodule

// ----- rtl/core/kot_checker.sv -----
`timescale 1ns / 1ps
module kot_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 token_valid,
  input logic                 token_stall,
  input kot_pkg::token_item_t token
);
  import kot_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token))
    else $error("stalled token changed");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind == KIND_END |-> token.last_of_run)
    else $error("end token not last of run");

  a_end_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind == KIND_END |-> token.token_length == '0
      && token.operator_code == '0)
    else $error("end token has length or code");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token.token_kind <= KIND_ERR && token.line_number != '0)
    else $error("bad kind or line");

endmodule

bind keyword_operator_tokenizer_core kot_checker u_kot_checker (
  .clk         (clk),
  .rst         (rst),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token       (token)
);
